>>> src/tle_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_pkg: shared types, codes and microprogram of the line editor
// Word formats, datapath control word, status word, byte classes and the
// microcode ROM with its dispatch map.
// ----------------------------------------------------------------------------
package tle_pkg;

  localparam int LINE_BYTES = 16;
  localparam int CNT_W      = $clog2(LINE_BYTES + 1);
  localparam int IDX_W      = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
  localparam int UPC_W      = 5;

  // result channels
  localparam logic [1:0] CH_ECHO = 2'd0;
  localparam logic [1:0] CH_CHAR = 2'd1;
  localparam logic [1:0] CH_EOF  = 2'd2;
  localparam logic [1:0] CH_DROP = 2'd3;

  // input kinds
  localparam logic KIND_BYTE = 1'b0;

  // ASCII
  localparam logic [7:0] ASC_ETX   = 8'h03;
  localparam logic [7:0] ASC_BS    = 8'h08;
  localparam logic [7:0] ASC_TAB   = 8'h09;
  localparam logic [7:0] ASC_NL    = 8'h0a;
  localparam logic [7:0] ASC_SO    = 8'h0e;
  localparam logic [7:0] ASC_SI    = 8'h0f;
  localparam logic [7:0] ASC_NAK   = 8'h15;
  localparam logic [7:0] ASC_SP    = 8'h20;
  localparam logic [7:0] ASC_PLUS  = 8'h2b;
  localparam logic [7:0] ASC_GT    = 8'h3e;
  localparam logic [7:0] ASC_C     = 8'h43;
  localparam logic [7:0] ASC_CARET = 8'h5e;
  localparam logic [7:0] ASC_DEL   = 8'h7f;
  localparam logic [7:0] ASC_NUL   = 8'h00;

  // byte classes
  localparam logic [2:0] CL_OTHER   = 3'd0;
  localparam logic [2:0] CL_NL      = 3'd1;
  localparam logic [2:0] CL_RAW_ON  = 3'd2;
  localparam logic [2:0] CL_RAW_OFF = 3'd3;
  localparam logic [2:0] CL_INTR    = 3'd4;
  localparam logic [2:0] CL_ERASE   = 3'd5;
  localparam logic [2:0] CL_KILL    = 3'd6;
  localparam logic [2:0] CL_PRINT   = 3'd7;

  // byte sources
  localparam logic [1:0] BS_LIT    = 2'd0;
  localparam logic [1:0] BS_EDIT   = 2'd1;
  localparam logic [1:0] BS_MEM    = 2'd2;
  localparam logic [1:0] BS_PROMPT = 2'd3;

  // last-flag modes
  localparam logic [1:0] LM_0    = 2'd0;
  localparam logic [1:0] LM_1    = 2'd1;
  localparam logic [1:0] LM_FILL = 2'd2;

  // counter / flag ops
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_INC  = 2'd1;
  localparam logic [1:0] OP_DEC  = 2'd2;
  localparam logic [1:0] OP_CLR  = 2'd3;
  localparam logic [1:0] FL_HOLD = 2'd0;
  localparam logic [1:0] FL_SET  = 2'd1;
  localparam logic [1:0] FL_CLR  = 2'd2;

  // jump conditions
  localparam logic [3:0] C_NEXT      = 4'd0;
  localparam logic [3:0] C_ALWAYS    = 4'd1;
  localparam logic [3:0] C_NO_WORD   = 4'd2;
  localparam logic [3:0] C_BYTE      = 4'd3;
  localparam logic [3:0] C_WAITING   = 4'd4;
  localparam logic [3:0] C_READ_GE   = 4'd5;
  localparam logic [3:0] C_FILL_ZERO = 4'd6;
  localparam logic [3:0] C_FILL_NZ   = 4'd7;
  localparam logic [3:0] C_FILL_FULL = 4'd8;
  localparam logic [3:0] C_DISPATCH  = 4'd9;

  // microprogram labels
  localparam logic [UPC_W-1:0] S_IDLE      = 5'd0;
  localparam logic [UPC_W-1:0] S_KIND      = 5'd1;
  localparam logic [UPC_W-1:0] S_REQ       = 5'd2;
  localparam logic [UPC_W-1:0] S_REQ_AVAIL = 5'd3;
  localparam logic [UPC_W-1:0] S_DELIVER   = 5'd4;
  localparam logic [UPC_W-1:0] S_PROMPT    = 5'd5;
  localparam logic [UPC_W-1:0] S_PROMPT_SP = 5'd6;
  localparam logic [UPC_W-1:0] S_BYTE      = 5'd7;
  localparam logic [UPC_W-1:0] S_DROP      = 5'd8;
  localparam logic [UPC_W-1:0] S_DISPATCH  = 5'd9;
  localparam logic [UPC_W-1:0] S_NL        = 5'd10;
  localparam logic [UPC_W-1:0] S_NL_ECHO   = 5'd11;
  localparam logic [UPC_W-1:0] S_RAW_ON    = 5'd12;
  localparam logic [UPC_W-1:0] S_RAW_OFF   = 5'd13;
  localparam logic [UPC_W-1:0] S_INTR      = 5'd14;
  localparam logic [UPC_W-1:0] S_INTR_C    = 5'd15;
  localparam logic [UPC_W-1:0] S_INTR_NL   = 5'd16;
  localparam logic [UPC_W-1:0] S_INTR_EOF  = 5'd17;
  localparam logic [UPC_W-1:0] S_ERASE     = 5'd18;
  localparam logic [UPC_W-1:0] S_ERASE_BS  = 5'd19;
  localparam logic [UPC_W-1:0] S_ERASE_SP  = 5'd20;
  localparam logic [UPC_W-1:0] S_ERASE_BS2 = 5'd21;
  localparam logic [UPC_W-1:0] S_KILL      = 5'd22;
  localparam logic [UPC_W-1:0] S_KILL_BS   = 5'd23;
  localparam logic [UPC_W-1:0] S_KILL_SP   = 5'd24;
  localparam logic [UPC_W-1:0] S_KILL_BS2  = 5'd25;
  localparam logic [UPC_W-1:0] S_KILL_DONE = 5'd26;
  localparam logic [UPC_W-1:0] S_PRINT     = 5'd27;
  localparam logic [UPC_W-1:0] S_PRINT_WR  = 5'd28;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_in;
    logic       continuation;
  } in_word_t;

  typedef struct packed {
    logic [1:0] channel;
    logic [7:0] byte_out;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic             latch;
    logic             emit;
    logic             gate;      // echo suppressed in raw mode
    logic [1:0]       ch;
    logic [1:0]       bsrc;
    logic [7:0]       lit;
    logic [1:0]       last_mode;
    logic [3:0]       cond;
    logic [UPC_W-1:0] target;
    logic [1:0]       fill_op;
    logic [1:0]       read_op;
    logic [1:0]       wait_op;
    logic [1:0]       raw_op;
    logic             mem_wr;
  } ctl_t;

  typedef struct packed {
    logic       in_valid;
    logic       byte_item;
    logic       waiting;
    logic       read_ge;
    logic       fill_zero;
    logic       fill_full;
    logic [2:0] cls;
    logic       stall;
  } stat_t;

  localparam ctl_t CTL_NOP = '{default: '0};

  function automatic logic [UPC_W-1:0] tle_dispatch(input logic [2:0] cls);
    logic [UPC_W-1:0] t;
    unique case (cls)
      CL_NL:      t = S_NL;
      CL_RAW_ON:  t = S_RAW_ON;
      CL_RAW_OFF: t = S_RAW_OFF;
      CL_INTR:    t = S_INTR;
      CL_ERASE:   t = S_ERASE;
      CL_KILL:    t = S_KILL;
      CL_PRINT:   t = S_PRINT;
      default:    t = S_IDLE;
    endcase
    return t;
  endfunction

  function automatic ctl_t tle_rom(input logic [UPC_W-1:0] pc);
    ctl_t w;
    w = CTL_NOP;
    unique case (pc)
      S_IDLE: begin
        w.latch = 1'b1; w.cond = C_NO_WORD; w.target = S_IDLE;
      end
      S_KIND: begin
        w.cond = C_BYTE; w.target = S_BYTE;
      end
      S_REQ: begin
        w.cond = C_WAITING; w.target = S_IDLE;
      end
      S_REQ_AVAIL: begin
        w.cond = C_READ_GE; w.target = S_PROMPT;
      end
      S_DELIVER: begin
        w.emit = 1'b1; w.ch = CH_CHAR; w.bsrc = BS_MEM; w.last_mode = LM_1;
        w.read_op = OP_INC; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_PROMPT: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.bsrc = BS_PROMPT;
      end
      S_PROMPT_SP: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_SP; w.last_mode = LM_1;
        w.fill_op = OP_CLR; w.read_op = OP_CLR; w.wait_op = FL_SET;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_BYTE: begin
        w.cond = C_WAITING; w.target = S_DISPATCH;
      end
      S_DROP: begin
        w.emit = 1'b1; w.ch = CH_DROP; w.lit = ASC_NUL; w.last_mode = LM_1;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_DISPATCH: begin
        w.cond = C_DISPATCH;
      end
      S_NL: begin
        w.mem_wr = 1'b1; w.fill_op = OP_INC; w.wait_op = FL_CLR;
      end
      S_NL_ECHO: begin
        w.emit = 1'b1; w.gate = 1'b1; w.ch = CH_ECHO; w.bsrc = BS_EDIT;
        w.cond = C_ALWAYS; w.target = S_DELIVER;
      end
      S_RAW_ON: begin
        w.raw_op = FL_SET; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_RAW_OFF: begin
        w.raw_op = FL_CLR; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_INTR: begin
        w.emit = 1'b1; w.gate = 1'b1; w.ch = CH_ECHO; w.lit = ASC_CARET;
      end
      S_INTR_C: begin
        w.emit = 1'b1; w.gate = 1'b1; w.ch = CH_ECHO; w.lit = ASC_C;
      end
      S_INTR_NL: begin
        w.emit = 1'b1; w.gate = 1'b1; w.ch = CH_ECHO; w.lit = ASC_NL;
      end
      S_INTR_EOF: begin
        w.emit = 1'b1; w.ch = CH_EOF; w.lit = ASC_NUL; w.last_mode = LM_1;
        w.wait_op = FL_CLR; w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_ERASE: begin
        w.cond = C_FILL_ZERO; w.target = S_IDLE;
      end
      S_ERASE_BS: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_BS; w.fill_op = OP_DEC;
      end
      S_ERASE_SP: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_SP;
      end
      S_ERASE_BS2: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_BS; w.last_mode = LM_1;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_KILL: begin
        w.cond = C_FILL_ZERO; w.target = S_IDLE;
      end
      S_KILL_BS: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_BS; w.fill_op = OP_DEC;
      end
      S_KILL_SP: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_SP;
      end
      S_KILL_BS2: begin
        w.emit = 1'b1; w.ch = CH_ECHO; w.lit = ASC_BS; w.last_mode = LM_FILL;
        w.cond = C_FILL_NZ; w.target = S_KILL_BS;
      end
      S_KILL_DONE: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      S_PRINT: begin
        w.cond = C_FILL_FULL; w.target = S_IDLE;
      end
      S_PRINT_WR: begin
        w.emit = 1'b1; w.gate = 1'b1; w.ch = CH_ECHO; w.bsrc = BS_EDIT;
        w.last_mode = LM_1; w.mem_wr = 1'b1; w.fill_op = OP_INC;
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = S_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

>>> src/tle_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module tle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/tle_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_seq: microcode sequencer
// Step counter, control ROM and conditional / dispatch branching.
// ----------------------------------------------------------------------------
module tle_seq import tle_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  stat_t st,
  output ctl_t  ctl
);

  logic [UPC_W-1:0] upc_r, upc_nxt;
  logic             take;

  assign ctl = tle_rom(upc_r);

  always_comb begin
    unique case (ctl.cond)
      C_NEXT:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_WORD:   take = !st.in_valid;
      C_BYTE:      take = st.byte_item;
      C_WAITING:   take = st.waiting;
      C_READ_GE:   take = st.read_ge;
      C_FILL_ZERO: take = st.fill_zero;
      C_FILL_NZ:   take = !st.fill_zero;
      C_FILL_FULL: take = st.fill_full;
      C_DISPATCH:  take = 1'b1;
      default:     take = 1'b1;
    endcase
  end

  always_comb begin
    if (st.stall) begin
      upc_nxt = upc_r;
    end else if (ctl.cond == C_DISPATCH) begin
      upc_nxt = tle_dispatch(st.cls);
    end else if (take) begin
      upc_nxt = ctl.target;
    end else begin
      upc_nxt = upc_r + UPC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r <= S_IDLE;
    end else begin
      upc_r <= upc_nxt;
    end
  end

endmodule

>>> src/tle_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tle_dp: line editor datapath
// Input word latch, line counters, mode flags, byte classifier, result mux
// and the output register.
// ----------------------------------------------------------------------------
module tle_dp import tle_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ctl_t             ctl,
  output stat_t            st,
  input  logic             in_valid,
  input  in_word_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_word_t        out_data,
  output logic             mem_we,
  output logic [IDX_W-1:0] mem_waddr,
  output logic [7:0]       mem_wdata,
  output logic [IDX_W-1:0] mem_raddr,
  input  logic [7:0]       mem_rdata
);

  in_word_t         word_r;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] read_r, read_nxt;
  logic             raw_r, raw_nxt;
  logic             wait_r, wait_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_word_t        out_data_r, out_data_nxt;

  logic       emit_eff;
  logic       go;
  logic [7:0] c;
  logic [7:0] edit_byte;
  logic [7:0] res_byte;
  logic       res_last;
  logic [2:0] cls;

  assign c         = word_r.byte_in;
  assign edit_byte = (c == ASC_TAB) ? ASC_SP : c;

  always_comb begin
    if (c == ASC_NL) begin
      cls = CL_NL;
    end else if (c == ASC_SO) begin
      cls = CL_RAW_ON;
    end else if (c == ASC_SI) begin
      cls = CL_RAW_OFF;
    end else if (c == ASC_ETX) begin
      cls = CL_INTR;
    end else if (c == ASC_BS || c == ASC_DEL) begin
      cls = CL_ERASE;
    end else if (c == ASC_NAK) begin
      cls = CL_KILL;
    end else if (c == ASC_TAB || c >= ASC_SP) begin
      cls = CL_PRINT;
    end else begin
      cls = CL_OTHER;
    end
  end

  // emit stalls only while the output register is full and not taken
  assign emit_eff = ctl.emit && !(ctl.gate && raw_r);
  assign go       = !(emit_eff && out_valid_r && !out_ready);

  always_comb begin
    st.in_valid  = in_valid;
    st.byte_item = (word_r.kind == KIND_BYTE);
    st.waiting   = wait_r;
    st.read_ge   = (read_r >= fill_r);
    st.fill_zero = (fill_r == '0);
    st.fill_full = (fill_r >= CNT_W'(LINE_BYTES - 1));
    st.cls       = cls;
    st.stall     = !go;
  end

  always_comb begin
    case (ctl.bsrc)
      BS_EDIT:   res_byte = edit_byte;
      BS_MEM:    res_byte = mem_rdata;
      BS_PROMPT: res_byte = word_r.continuation ? ASC_PLUS : ASC_GT;
      default:   res_byte = ctl.lit;
    endcase
    case (ctl.last_mode)
      LM_1:    res_last = 1'b1;
      LM_FILL: res_last = (fill_r == '0);
      default: res_last = 1'b0;
    endcase
  end

  always_comb begin
    fill_nxt = fill_r;
    read_nxt = read_r;
    raw_nxt  = raw_r;
    wait_nxt = wait_r;
    if (go) begin
      case (ctl.fill_op)
        OP_INC:  fill_nxt = fill_r + CNT_W'(1);
        OP_DEC:  fill_nxt = fill_r - CNT_W'(1);
        OP_CLR:  fill_nxt = '0;
        default: fill_nxt = fill_r;
      endcase
      case (ctl.read_op)
        OP_INC:  read_nxt = read_r + CNT_W'(1);
        OP_CLR:  read_nxt = '0;
        default: read_nxt = read_r;
      endcase
      case (ctl.raw_op)
        FL_SET:  raw_nxt = 1'b1;
        FL_CLR:  raw_nxt = 1'b0;
        default: raw_nxt = raw_r;
      endcase
      case (ctl.wait_op)
        FL_SET:  wait_nxt = 1'b1;
        FL_CLR:  wait_nxt = 1'b0;
        default: wait_nxt = wait_r;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (go && emit_eff) begin
      out_valid_nxt         = 1'b1;
      out_data_nxt.channel  = ctl.ch;
      out_data_nxt.byte_out = res_byte;
      out_data_nxt.last     = res_last;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      read_r      <= '0;
      raw_r       <= 1'b0;
      wait_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      read_r      <= read_nxt;
      raw_r       <= raw_nxt;
      wait_r      <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.latch && in_valid) begin
      word_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

  assign mem_we    = go && ctl.mem_wr;
  assign mem_waddr = fill_r[IDX_W-1:0];
  assign mem_wdata = edit_byte;
  assign mem_raddr = read_r[IDX_W-1:0];

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> src/terminal_line_editor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_unit: canonical-mode terminal line editor
// Collects and edits a terminal line and hands it to a reader a byte at a time.
// ----------------------------------------------------------------------------
// A word on the input channel is either a terminal byte (kind 0) or a read
// request from the reader (kind 1); each word yields zero or more result
// words on the output channel, the final one flagged with last. The editor
// takes one input word at a time: in_ready is high only while the sequencer
// sits on its idle step. The microcode steps run in turn, and a step that emits
// a result stalls while the output register is still full and out_ready is low.
// Results leave through a single output register, so a finished word can
// wait for the reader while the sequencer moves on to its next step. The
// line is held in a 16-byte RAM with registered read; its contents need no
// clearing after reset, since only written bytes are ever read back.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit import tle_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  ctl_t             ctl;
  stat_t            st;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic [IDX_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  // sequencer: step counter plus control ROM
  tle_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl)
  );

  // only the idle step latches a new word
  assign in_ready = ctl.latch;

  // datapath: counters, flags, result mux, output register
  tle_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .st        (st),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // line store: written at the fill count, read at the read count
  tle_ram #(
    .WIDTH (8),
    .DEPTH (LINE_BYTES)
  ) u_line (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule

>>> sim/terminal_line_editor_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_line_editor_unit_test: self-checking bench for the line editor
// Sends terminal bytes and read requests, runs its own copy of the editing
// rules and matches every result word in order, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module terminal_line_editor_unit_test;
  import tle_pkg::*;

  // A request word carries kind 1; the package names only the byte kind.
  localparam logic KIND_REQ     = ~KIND_BYTE;
  localparam int   ITEMS        = 320;
  // Longest quiet stretch after the last due word: a full line kill plus slack.
  localparam int   DRAIN_CYCLES = 100;

  typedef struct {
    in_word_t word;
    bit       hold;   // wait for every due result before sending this word
  } term_item_t;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_word_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  term_item_t term_words[$];    // words still to be sent
  out_word_t  line_results[$];  // words the editor owes, oldest first
  int         mismatches = 0;
  int         send_gap   = 0;
  int         recv_gap   = 0;
  logic       calm       = 1'b0; // no idling on either side near the end

  // Editor state as the bench sees it.
  logic [7:0]       line_mem[LINE_BYTES];
  logic [CNT_W-1:0] fill_cnt     = '0;
  logic [CNT_W-1:0] read_cnt     = '0;
  logic             echo_off     = 1'b0;
  logic             line_waiting = 1'b0;

  terminal_line_editor_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
  end

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic void owe(input logic [1:0] ch, input logic [7:0] b);
    out_word_t w;
    w.channel  = ch;
    w.byte_out = b;
    w.last     = 1'b0;
    line_results.push_back(w);
  endfunction

  function automatic void erase_char();
    fill_cnt = fill_cnt - 1'b1;
    owe(CH_ECHO, ASC_BS);
    owe(CH_ECHO, ASC_SP);
    owe(CH_ECHO, ASC_BS);
  endfunction

  function automatic void hand_to_reader();
    logic [7:0] b;
    b = (read_cnt < LINE_BYTES) ? line_mem[read_cnt] : ASC_NUL;
    read_cnt = read_cnt + 1'b1;
    owe(CH_CHAR, b);
  endfunction

  // Applies one accepted word to the bench state and queues what it causes.
  function automatic void edit_line(input in_word_t w);
    int         base;
    logic [7:0] c;
    base = line_results.size();
    c    = w.byte_in;
    if (w.kind == KIND_REQ) begin
      if (line_waiting) begin
        // second request while one is open: no effect
      end else if (read_cnt < fill_cnt) begin
        hand_to_reader();
      end else begin
        // line drained: prompt and start collecting
        owe(CH_ECHO, w.continuation ? ASC_PLUS : ASC_GT);
        owe(CH_ECHO, ASC_SP);
        read_cnt     = '0;
        fill_cnt     = '0;
        line_waiting = 1'b1;
      end
    end else if (!line_waiting) begin
      owe(CH_DROP, ASC_NUL);
    end else begin
      case (c)
        ASC_NL: begin
          if (fill_cnt < LINE_BYTES) begin
            line_mem[fill_cnt] = c;
            fill_cnt = fill_cnt + 1'b1;
          end
          if (!echo_off) owe(CH_ECHO, c);
          line_waiting = 1'b0;
          hand_to_reader();
        end
        ASC_SO: echo_off = 1'b1;
        ASC_SI: echo_off = 1'b0;
        ASC_ETX: begin
          if (!echo_off) begin
            owe(CH_ECHO, ASC_CARET);
            owe(CH_ECHO, ASC_C);
            owe(CH_ECHO, ASC_NL);
          end
          owe(CH_EOF, ASC_NUL);
          line_waiting = 1'b0;
        end
        ASC_BS, ASC_DEL: begin
          // erase echo goes out even in raw mode
          if (fill_cnt != 0) erase_char();
        end
        ASC_NAK: begin
          while (fill_cnt != 0) erase_char();
        end
        default: begin
          if (c == ASC_TAB) c = ASC_SP;
          // other controls fall through silently; a full line drops the byte
          if (c >= ASC_SP && fill_cnt < LINE_BYTES - 1) begin
            line_mem[fill_cnt] = c;
            fill_cnt = fill_cnt + 1'b1;
            if (!echo_off) owe(CH_ECHO, c);
          end
        end
      endcase
    end
    if (line_results.size() > base) line_results[$].last = 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("mismatch at %0t ns: %s", $realtime, what);
  endtask

  // --------------------------------------------------------------------------
  // Input side: one word in flight, random idle gaps between words
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : driver
    logic       go;
    term_item_t head;
    go = in_valid;
    if (!rst_n) begin
      go = 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        edit_line(in_data);
        go = 1'b0;
      end
      if (!go) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
          // this cycle counts as the first of the burst
          send_gap = $urandom_range(0, 11);
        end else if (term_words.size() != 0 &&
                     !(term_words[0].hold && line_results.size() != 0)) begin
          head = term_words.pop_front();
          go   = 1'b1;
          in_data <= head.word;
        end
      end
    end
    in_valid <= go;
    calm     <= (term_words.size() < 40);
  end

  // --------------------------------------------------------------------------
  // Output side: match each accepted word, stall in bursts
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    out_word_t due;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (line_results.size() == 0) begin
          report_mismatch($sformatf("word ch=%0d byte=%h last=%b with nothing due",
                                    out_data.channel, out_data.byte_out, out_data.last));
        end else begin
          due = line_results.pop_front();
          if (out_data.channel !== due.channel)
            report_mismatch($sformatf("channel %0d, want %0d",
                                      out_data.channel, due.channel));
          if (out_data.byte_out !== due.byte_out)
            report_mismatch($sformatf("byte %h, want %h (ch %0d)",
                                      out_data.byte_out, due.byte_out, due.channel));
          if (out_data.last !== due.last)
            report_mismatch($sformatf("last %b, want %b", out_data.last, due.last));
        end
      end
      if (recv_gap != 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 11);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic in_word_t term_byte(input logic [7:0] c);
    in_word_t w;
    w.kind         = KIND_BYTE;
    w.byte_in      = c;
    w.continuation = 1'($urandom_range(0, 1));
    return w;
  endfunction

  // byte_in is don't-care on a request, so it gets noise
  function automatic in_word_t read_req(input logic cont);
    in_word_t w;
    w.kind         = KIND_REQ;
    w.byte_in      = 8'($urandom_range(0, 255));
    w.continuation = cont;
    return w;
  endfunction

  function automatic void queue_word(input in_word_t w, input bit hold);
    term_item_t t;
    t.word = w;
    t.hold = hold;
    term_words.push_back(t);
  endfunction

  function automatic logic [7:0] any_printable();
    logic [7:0] c;
    do c = 8'($urandom_range(32, 255)); while (c == ASC_DEL);
    return c;
  endfunction

  initial begin : stimulus
    int         fill_guess;
    int         line_len;
    int         drain;
    logic [7:0] c;

    // Directed: drop, prompts, ignored request, byte extremes, erase and kill,
    // raw mode around echo, interrupt, stale delivery after an interrupt.
    queue_word(term_byte(8'h41), 0);     // nobody reading: dropped
    queue_word(read_req(1'b0), 0);       // "> "
    queue_word(read_req(1'b1), 0);       // already waiting: ignored
    queue_word(term_byte(ASC_BS), 0);    // erase on empty line
    queue_word(term_byte(ASC_SP), 0);
    queue_word(term_byte(8'h7e), 0);
    queue_word(term_byte(8'h80), 0);
    queue_word(term_byte(8'hff), 0);
    queue_word(term_byte(ASC_TAB), 0);   // stored as space
    queue_word(term_byte(8'h01), 0);     // plain control: silent
    queue_word(term_byte(8'h1f), 0);
    queue_word(term_byte(ASC_DEL), 0);
    queue_word(term_byte(ASC_BS), 0);
    queue_word(term_byte(ASC_SO), 0);    // raw on
    queue_word(term_byte(8'h61), 0);     // stored, no echo
    queue_word(term_byte(ASC_BS), 0);    // erase still echoes
    queue_word(term_byte(ASC_NAK), 1);   // kill the rest, after a full drain
    queue_word(term_byte(ASC_ETX), 0);   // raw interrupt: EOF only
    queue_word(read_req(1'b1), 0);       // "+ "
    queue_word(term_byte(ASC_SI), 0);    // raw off
    queue_word(term_byte(8'h5a), 0);
    queue_word(term_byte(ASC_ETX), 0);   // "^C\n" then EOF
    queue_word(read_req(1'b0), 0);       // interrupted byte still readable
    queue_word(read_req(1'b0), 0);       // "> "
    queue_word(term_byte(ASC_SO), 0);
    queue_word(term_byte(ASC_NL), 0);    // newline in raw: no echo
    queue_word(term_byte(ASC_SI), 0);

    // Random: mostly whole lines with random content, drained by requests;
    // the rest drops, half-typed lines and loose words.
    while (term_words.size() < ITEMS) begin
      case ($urandom_range(0, 9))
        7: queue_word(term_byte(8'($urandom_range(0, 255))), 0);
        8: begin
          queue_word(read_req(1'($urandom_range(0, 1))), 0);
          repeat ($urandom_range(1, 4))
            queue_word(term_byte(8'($urandom_range(0, 255))), 0);
        end
        9: begin
          queue_word(($urandom_range(0, 1) != 0) ? read_req(1'($urandom_range(0, 1)))
                                                 : term_byte(8'($urandom_range(0, 255))),
                     0);
        end
        default: begin
          queue_word(read_req(1'($urandom_range(0, 1))), $urandom_range(0, 11) == 0);
          fill_guess = 0;
          // a few long lines run into the full-line limit
          line_len = ($urandom_range(0, 5) == 0) ? $urandom_range(12, 20)
                                                 : $urandom_range(0, 6);
          repeat (line_len) begin
            case ($urandom_range(0, 19))
              0:       c = ASC_TAB;
              1:       c = ASC_BS;
              2:       c = ASC_DEL;
              3:       c = ($urandom_range(0, 3) == 0) ? ASC_NAK : any_printable();
              4:       c = ASC_SO;
              5:       c = ASC_SI;
              6:       c = 8'($urandom_range(0, 255));
              default: c = any_printable();
            endcase
            if (c == ASC_BS || c == ASC_DEL) begin
              if (fill_guess > 0) fill_guess--;
            end else if (c == ASC_NAK) begin
              fill_guess = 0;
            end else if ((c == ASC_TAB || c >= ASC_SP) && fill_guess < LINE_BYTES - 1) begin
              fill_guess++;
            end
            queue_word(term_byte(c), 0);
          end
          // newline hands over the first byte itself, so the newline counts and one
          // request is saved; after an interrupt the same requests read the stale line
          queue_word(term_byte(($urandom_range(0, 6) != 0) ? ASC_NL : ASC_ETX), 0);
          drain = fill_guess;
          repeat (drain) queue_word(read_req(1'($urandom_range(0, 1))), 0);
        end
      endcase
    end

    while (term_words.size() != 0 || in_valid || line_results.size() != 0)
      @(posedge clk);
    // catch stray words after the last due one
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && line_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Worst case is far below this: ~400 words, each at most 45 results with
  // output stalls, plus a send gap and a full line kill.
  initial begin
    #8ms;
    $display("status: fail");
    $finish;
  end

endmodule
